/* rtl/kwf_pkg.sv */
// Shared types, constants and reset values of the K-weighting filter.
`timescale 1ns / 1ps

package kwf_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int COEF_BITS_DEF   = 32;

   localparam int NUM_REGS     = 7;
   localparam int REG_IDX_BITS = 3;

   // Register map of the configuration port.
   typedef enum logic [REG_IDX_BITS-1:0] {
      REG_SHELF_B0 = 3'd0,
      REG_SHELF_B1 = 3'd1,
      REG_SHELF_B2 = 3'd2,
      REG_SHELF_A1 = 3'd3,
      REG_SHELF_A2 = 3'd4,
      REG_PASS_A1  = 3'd5,
      REG_PASS_A2  = 3'd6
   } reg_idx_type;

   localparam logic [REG_IDX_BITS-1:0] REG_LAST = REG_PASS_A2;

   // Multiply-accumulate steps, in issue order. The first two form the
   // shelf input sum, the other five form the section output sum.
   typedef enum logic [2:0] {
      MAC_SHELF_A1 = 3'd0,
      MAC_SHELF_A2 = 3'd1,
      MAC_SHELF_B0 = 3'd2,
      MAC_SHELF_B1 = 3'd3,
      MAC_SHELF_B2 = 3'd4,
      MAC_PASS_A1  = 3'd5,
      MAC_PASS_A2  = 3'd6
   } mac_type;

   localparam int X_MACS     = 2;
   localparam int Y_MACS     = 5;
   localparam int PIPE_DRAIN = 3;
   localparam int STEP_BITS  = 4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic    load;
      logic    issue;
      logic    hi;
      mac_type mac;
      logic    latch_x;
      logic    latch_y;
      logic    finish;
   } cmd_type;

   // Status from the datapath.
   typedef struct packed {
      logic pipe_busy;
   } status_type;

   // 48 kHz coefficients, Q3.29.
   localparam logic signed [31:0] COEF_RESET_Q29 [NUM_REGS] = '{
      32'sd824163883, -32'sd1445093388, 32'sd643382241, -32'sd907665797,
      32'sd393247621, -32'sd1068398592, 32'sd531540990
   };

   // Reset value of a coefficient rescaled to coef_bits-3 fraction bits.
   function automatic logic signed [63:0] coef_reset(input logic [REG_IDX_BITS-1:0] idx,
                                                     input int coef_bits);
      logic signed [63:0] wide;
      wide = 64'(COEF_RESET_Q29[idx]);
      if (coef_bits >= 32) begin
         coef_reset = wide <<< (coef_bits - 32);
      end else begin
         coef_reset = wide >>> (32 - coef_bits);
      end
   endfunction

endpackage

/* rtl/k_weighting_filter_top.sv */
// Top level of the K-weighting filter: controller, datapath and checks.
`timescale 1ns / 1ps

// K-weighting filter after ITU-R BS.1770: a high-shelf section followed by
// a high-pass section, both direct form II, in fixed point.
// Input channel: req_valid/req_ready with req_audio_in, one signed PCM
// sample per transfer. Result channel: rsp_valid/rsp_ready with
// rsp_weighted_out, one saturated sample with two headroom bits.
// The user must write coefficients through csr_write_en/csr_index/csr_wdata
// only while the block is idle; the block itself does not enforce this.
// Writes to index 7 are dropped. One signed multiplier of COEF_BITS by half
// a delay word is shared by all seven coefficient products, and each product
// takes two passes through it. A sample is issued for the shelf input sum,
// drained and saturated, issued for the section output sum, drained and
// saturated, then combined, saturated and retired. A new sample is taken
// only once the previous one has retired.
// The result register decouples the channels: a new sample is accepted
// while the previous result still waits. If the receiver stalls, the next
// sample waits in its last step until the result register is free.
// Reset restores the 48 kHz coefficients, clears all delays and leaves
// both channels empty.
module k_weighting_filter_top #(
   parameter int SAMPLE_BITS = kwf_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = kwf_pkg::COEF_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [SAMPLE_BITS-1:0]           req_audio_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [SAMPLE_BITS+1:0]           rsp_weighted_out,
   input  logic                             csr_write_en,
   input  logic [kwf_pkg::REG_IDX_BITS-1:0] csr_index,
   input  logic [COEF_BITS-1:0]             csr_wdata
);

   kwf_pkg::cmd_type    cmd;
   kwf_pkg::status_type status;

   kwf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kwf_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .audio_in     (req_audio_in),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .weighted_out (rsp_weighted_out)
   );

   // Once a sample is taken, the block is busy with it in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while a sample is in progress");

   // A sum is saturated only after the multiply pipeline has drained.
   a_latch_after_drain: assert property (@(posedge clock) disable iff (reset)
      (cmd.latch_x || cmd.latch_y) |-> !status.pipe_busy)
      else $error("sum latched while products are still in flight");

   // A new result appears only when a sample retires.
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.finish))
      else $error("result raised without a retiring sample");

   // No multiply is issued or still in flight in the same cycle a sample retires.
   a_no_issue_at_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !cmd.issue && !status.pipe_busy)
      else $error("sample retired with multiply work outstanding");

endmodule

/* rtl/kwf_ctrl.sv */
// Sequencer of the K-weighting filter: steps one sample through the datapath.
`timescale 1ns / 1ps

module kwf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  kwf_pkg::status_type status,
   output kwf_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_X_ISSUE,
      ST_X_DRAIN,
      ST_X_LATCH,
      ST_Y_ISSUE,
      ST_Y_DRAIN,
      ST_Y_LATCH,
      ST_FINISH
   } state_type;

   localparam logic [kwf_pkg::STEP_BITS-1:0] X_LAST =
      kwf_pkg::STEP_BITS'(2 * kwf_pkg::X_MACS - 1);
   localparam logic [kwf_pkg::STEP_BITS-1:0] Y_LAST =
      kwf_pkg::STEP_BITS'(2 * kwf_pkg::Y_MACS - 1);
   localparam logic [kwf_pkg::STEP_BITS-1:0] DRAIN_LAST =
      kwf_pkg::STEP_BITS'(kwf_pkg::PIPE_DRAIN - 1);

   state_type                      state_ff, state_in;
   logic [kwf_pkg::STEP_BITS-1:0]  step_ff, step_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      cmd.mac      = kwf_pkg::MAC_SHELF_A1;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = ST_X_ISSUE;
               step_in  = '0;
            end
         end
         ST_X_ISSUE: begin
            cmd.issue = 1'b1;
            cmd.hi    = step_ff[0];
            cmd.mac   = kwf_pkg::mac_type'(3'(step_ff[kwf_pkg::STEP_BITS-1:1]));
            step_in   = step_ff + 1'b1;
            if (step_ff == X_LAST) begin
               state_in = ST_X_DRAIN;
               step_in  = '0;
            end
         end
         ST_X_DRAIN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == DRAIN_LAST && !status.pipe_busy) begin
               state_in = ST_X_LATCH;
            end
         end
         ST_X_LATCH: begin
            cmd.latch_x = 1'b1;
            state_in    = ST_Y_ISSUE;
            step_in     = '0;
         end
         ST_Y_ISSUE: begin
            cmd.issue = 1'b1;
            cmd.hi    = step_ff[0];
            cmd.mac   = kwf_pkg::mac_type'(3'(kwf_pkg::MAC_SHELF_B0)
                                           + 3'(step_ff[kwf_pkg::STEP_BITS-1:1]));
            step_in   = step_ff + 1'b1;
            if (step_ff == Y_LAST) begin
               state_in = ST_Y_DRAIN;
               step_in  = '0;
            end
         end
         ST_Y_DRAIN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == DRAIN_LAST && !status.pipe_busy) begin
               state_in = ST_Y_LATCH;
            end
         end
         ST_Y_LATCH: begin
            cmd.latch_y = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            // The result register must be free before the sample retires.
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/kwf_datapath.sv */
// Datapath of the K-weighting filter: coefficients, delays, shared MAC and output.
`timescale 1ns / 1ps

module kwf_datapath #(
   parameter int SAMPLE_BITS = kwf_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = kwf_pkg::COEF_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [SAMPLE_BITS-1:0]              audio_in,
   input  logic                                csr_write_en,
   input  logic [kwf_pkg::REG_IDX_BITS-1:0]    csr_index,
   input  logic [COEF_BITS-1:0]                csr_wdata,
   input  kwf_pkg::cmd_type                    cmd,
   output kwf_pkg::status_type                 status,
   output logic [SAMPLE_BITS+1:0]              weighted_out
);

   localparam int D   = SAMPLE_BITS + 16;     // delay width
   localparam int F   = COEF_BITS - 3;        // coefficient fraction bits
   localparam int LO  = (D + 1) / 2;          // low slice of a delay operand
   localparam int HI  = D - LO;               // high slice
   localparam int M   = COEF_BITS + LO + 1;   // multiplier result
   localparam int P   = COEF_BITS + D;        // full product
   localparam int A   = D + 6;                // accumulator
   localparam int W   = D + 3;                // output sum
   localparam int OUT = SAMPLE_BITS + 2;

   localparam logic [P-1:0] HALF = P'(1) << (F - 1);
   localparam logic [W-1:0] OUT_HALF = W'(1) << 15;

   logic signed [COEF_BITS-1:0] coef_ff [kwf_pkg::NUM_REGS];
   logic signed [63:0]          coef_wide [kwf_pkg::NUM_REGS];

   logic signed [D-1:0] z1_ff, z2_ff, z3_ff, z4_ff, x_ff, y_ff;
   logic signed [A-1:0] acc_ff;
   logic signed [M-1:0] mult_ff;
   logic signed [P-1:0] prod_ff;
   logic [OUT-1:0]      out_ff;

   logic c1_valid_ff, c1_hi_ff, c1_sub_ff;
   logic c2_valid_ff, c2_sub_ff;

   logic signed [COEF_BITS-1:0] coef_sel;
   logic signed [D-1:0]         opnd_sel;
   logic                        sub_sel;
   logic signed [LO:0]          part;
   logic signed [P-1:0]         mult_ext;
   logic signed [D+2:0]         rnd;
   logic signed [A-1:0]         rnd_ext;
   logic signed [D-1:0]         acc_sat;
   logic signed [W-1:0]         wsum;
   logic signed [SAMPLE_BITS+2:0] wq;
   logic [OUT-1:0]              w_sat;

   always_comb begin
      for (int i = 0; i < kwf_pkg::NUM_REGS; i++) begin
         coef_wide[i] = kwf_pkg::coef_reset(kwf_pkg::REG_IDX_BITS'(i), COEF_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < kwf_pkg::NUM_REGS; i++) begin
            coef_ff[i] <= coef_wide[i][COEF_BITS-1:0];
         end
      end else if (csr_write_en && csr_index <= kwf_pkg::REG_LAST) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // Operand selection for the step being issued.
   always_comb begin
      coef_sel = coef_ff[kwf_pkg::REG_SHELF_A1];
      opnd_sel = z1_ff;
      sub_sel  = 1'b1;
      unique case (cmd.mac)
         kwf_pkg::MAC_SHELF_A1: begin
            coef_sel = coef_ff[kwf_pkg::REG_SHELF_A1];
            opnd_sel = z1_ff;
            sub_sel  = 1'b1;
         end
         kwf_pkg::MAC_SHELF_A2: begin
            coef_sel = coef_ff[kwf_pkg::REG_SHELF_A2];
            opnd_sel = z2_ff;
            sub_sel  = 1'b1;
         end
         kwf_pkg::MAC_SHELF_B0: begin
            coef_sel = coef_ff[kwf_pkg::REG_SHELF_B0];
            opnd_sel = x_ff;
            sub_sel  = 1'b0;
         end
         kwf_pkg::MAC_SHELF_B1: begin
            coef_sel = coef_ff[kwf_pkg::REG_SHELF_B1];
            opnd_sel = z1_ff;
            sub_sel  = 1'b0;
         end
         kwf_pkg::MAC_SHELF_B2: begin
            coef_sel = coef_ff[kwf_pkg::REG_SHELF_B2];
            opnd_sel = z2_ff;
            sub_sel  = 1'b0;
         end
         kwf_pkg::MAC_PASS_A1: begin
            coef_sel = coef_ff[kwf_pkg::REG_PASS_A1];
            opnd_sel = z3_ff;
            sub_sel  = 1'b1;
         end
         kwf_pkg::MAC_PASS_A2: begin
            coef_sel = coef_ff[kwf_pkg::REG_PASS_A2];
            opnd_sel = z4_ff;
            sub_sel  = 1'b1;
         end
         default: begin
            coef_sel = '0;
            opnd_sel = '0;
            sub_sel  = 1'b0;
         end
      endcase
   end

   // The low slice enters as an unsigned value, the high slice carries the sign.
   assign part = cmd.hi ? {{(LO + 1 - HI){opnd_sel[D-1]}}, opnd_sel[D-1:LO]}
                        : {1'b0, opnd_sel[LO-1:0]};

   assign mult_ext = {{(P - M){mult_ff[M-1]}}, mult_ff};
   assign rnd      = prod_ff[P-1:F];
   assign rnd_ext  = {{3{rnd[D+2]}}, rnd};

   always_comb begin
      if (&acc_ff[A-1:D-1] || ~|acc_ff[A-1:D-1]) begin
         acc_sat = acc_ff[D-1:0];
      end else if (acc_ff[A-1]) begin
         acc_sat = {1'b1, {(D - 1){1'b0}}};
      end else begin
         acc_sat = {1'b0, {(D - 1){1'b1}}};
      end
   end

   // Fixed high-pass numerator 1, -2, 1, then round away the 16 fraction bits.
   assign wsum = {{3{y_ff[D-1]}}, y_ff} - {{2{z3_ff[D-1]}}, z3_ff, 1'b0}
               + {{3{z4_ff[D-1]}}, z4_ff} + OUT_HALF;
   assign wq   = wsum[W-1:16];

   always_comb begin
      if (wq[SAMPLE_BITS+2] == wq[SAMPLE_BITS+1]) begin
         w_sat = wq[OUT-1:0];
      end else if (wq[SAMPLE_BITS+2]) begin
         w_sat = {1'b1, {(OUT - 1){1'b0}}};
      end else begin
         w_sat = {1'b0, {(OUT - 1){1'b1}}};
      end
   end

   // Pipeline tags of the shared multiply-accumulate unit.
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
      end else begin
         c1_valid_ff <= cmd.issue;
         c2_valid_ff <= c1_valid_ff && c1_hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      c1_hi_ff  <= cmd.hi;
      c1_sub_ff <= sub_sel;
      c2_sub_ff <= c1_sub_ff;
      if (cmd.issue) begin
         mult_ff <= coef_sel * part;
      end
      if (c1_valid_ff) begin
         if (c1_hi_ff) begin
            prod_ff <= prod_ff + (mult_ext <<< LO);
         end else begin
            prod_ff <= mult_ext + HALF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c2_valid_ff) begin
         acc_ff <= c2_sub_ff ? acc_ff - rnd_ext : acc_ff + rnd_ext;
      end else if (cmd.load) begin
         acc_ff <= {{6{audio_in[SAMPLE_BITS-1]}}, audio_in, 16'b0};
      end else if (cmd.latch_x) begin
         acc_ff <= '0;
      end
      if (cmd.latch_x) begin
         x_ff <= acc_sat;
      end
      if (cmd.latch_y) begin
         y_ff <= acc_sat;
      end
      if (cmd.finish) begin
         out_ff <= w_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         z1_ff <= '0;
         z2_ff <= '0;
         z3_ff <= '0;
         z4_ff <= '0;
      end else if (cmd.finish) begin
         z2_ff <= z1_ff;
         z1_ff <= x_ff;
         z4_ff <= z3_ff;
         z3_ff <= y_ff;
      end
   end

   assign status.pipe_busy = c1_valid_ff || c2_valid_ff;
   assign weighted_out     = out_ff;

endmodule

/* tb/k_weighting_filter_top_tb.sv */
// Self-checking testbench of the K-weighting filter top level.
`timescale 1ns / 1ps

// Testbench of k_weighting_filter_top.
//
// A scoreboard class keeps its own copy of the seven coefficients and of
// the four delay words. For every accepted input transfer it computes the
// K-weighted sample the block must return, with the same rounding and
// saturation, and queues it. Every result transfer is checked against the
// oldest queued sample. Results without a pending sample, wrong values and
// samples still pending at the end are all counted as mismatches.
//
// The run goes through several coefficient sets: the 48 kHz values from
// reset, all registers at the largest and the smallest value, random
// values, a set with only the shelf b0 tap at one, and the
// 48 kHz values written back. The unstable sets drive the delay and output
// saturation hard. Coefficients are only written once the block has gone
// idle, which is safe because every sample yields exactly one result.
//
// Both channels idle at random, except for one phase with no idling at
// all. In the last phase the receiver holds off for a long stretch so the
// result register and the pipeline fill up and the input channel stalls.
module k_weighting_filter_top_tb;

   localparam int SAMPLE_W    = kwf_pkg::SAMPLE_BITS_DEF;
   localparam int COEF_W      = kwf_pkg::COEF_BITS_DEF;
   localparam int OUT_W       = kwf_pkg::SAMPLE_BITS_DEF + 2;
   localparam int DELAY_W     = kwf_pkg::SAMPLE_BITS_DEF + 16;
   localparam int IDLE_PCT    = 27;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 40;
   localparam int IDLE_GAP    = 4;
   localparam int CYCLE_LIMIT = 500000;

   // Index past the register map; the block must drop writes to it.
   localparam logic [kwf_pkg::REG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   // One in Q3.29.
   localparam logic [COEF_W-1:0] COEF_ONE = 32'h2000_0000;

   // Predicts the filter output sample by sample.
   class kweight_scoreboard;
      logic signed [COEF_W-1:0]  coef [kwf_pkg::NUM_REGS];
      logic signed [DELAY_W-1:0] shelf_z1, shelf_z2, pass_z1, pass_z2;
      logic signed [OUT_W-1:0]   weighted_expected [$];
      int unsigned               mismatches;

      function new();
         for (int i = 0; i < kwf_pkg::NUM_REGS; i++) coef[i] = kwf_pkg::COEF_RESET_Q29[i];
         shelf_z1 = '0;
         shelf_z2 = '0;
         pass_z1  = '0;
         pass_z2  = '0;
         mismatches = 0;
      endfunction

      function void set_coef(logic [kwf_pkg::REG_IDX_BITS-1:0] idx,
                             logic [COEF_W-1:0] value);
         if (idx <= kwf_pkg::REG_LAST) coef[idx] = value;
      endfunction

      // Coefficient times delay, rounded to 16 fraction bits, ties up.
      function logic signed [79:0] round_product(logic signed [COEF_W-1:0] c,
                                                 logic signed [DELAY_W-1:0] z);
         logic signed [79:0] cw, zw, p;
         cw = c;
         zw = z;
         p = cw * zw + (80'sd1 <<< (COEF_W - 4));
         return p >>> (COEF_W - 3);
      endfunction

      function logic signed [79:0] clamp(logic signed [79:0] v, int w);
         logic signed [79:0] hi, lo;
         hi = (80'sd1 <<< (w - 1)) - 80'sd1;
         lo = -hi - 80'sd1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] audio);
         logic signed [79:0] s, x, y, w;
         s = audio;
         s = s <<< 16;
         x = s - round_product(coef[kwf_pkg::REG_SHELF_A1], shelf_z1)
               - round_product(coef[kwf_pkg::REG_SHELF_A2], shelf_z2);
         x = clamp(x, DELAY_W);
         // The high-pass feedback is folded into the shelf output sum.
         y = round_product(coef[kwf_pkg::REG_SHELF_B0], x[DELAY_W-1:0])
           + round_product(coef[kwf_pkg::REG_SHELF_B1], shelf_z1)
           + round_product(coef[kwf_pkg::REG_SHELF_B2], shelf_z2)
           - round_product(coef[kwf_pkg::REG_PASS_A1], pass_z1)
           - round_product(coef[kwf_pkg::REG_PASS_A2], pass_z2);
         y = clamp(y, DELAY_W);
         w = y - 80'sd2 * pass_z1 + pass_z2;
         w = clamp((w + 80'sd32768) >>> 16, OUT_W);
         shelf_z2 = shelf_z1;
         shelf_z1 = x[DELAY_W-1:0];
         pass_z2  = pass_z1;
         pass_z1  = y[DELAY_W-1:0];
         weighted_expected.push_back(w[OUT_W-1:0]);
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_result(logic signed [OUT_W-1:0] got);
         logic signed [OUT_W-1:0] want;
         if (weighted_expected.size() == 0) begin
            report($sformatf("weighted_out %0d arrived with no sample pending", got));
         end else begin
            want = weighted_expected.pop_front();
            if (got !== want)
               report($sformatf("weighted_out got %0d, expected %0d", got, want));
         end
      endtask
   endclass

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic [SAMPLE_W-1:0]                req_audio_in;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic [OUT_W-1:0]                   rsp_weighted_out;
   logic                               csr_write_en;
   logic [kwf_pkg::REG_IDX_BITS-1:0]   csr_index;
   logic [COEF_W-1:0]                  csr_wdata;

   kweight_scoreboard board = new();

   // Knobs shared by the stimulus and the receiver processes.
   int  source_idle_pct = IDLE_PCT;
   int  sink_stall_pct  = IDLE_PCT;
   bit  hold_request    = 1'b0;
   int  cycle_count     = 0;

   logic [COEF_W-1:0] coef_plan [kwf_pkg::NUM_REGS];

   k_weighting_filter_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_audio_in     (req_audio_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_weighted_out (rsp_weighted_out),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // Offers one sample and returns at the falling edge after its transfer.
   // Valid is left high there, so the caller must either offer the next
   // sample or lower valid at that same edge.
   task send_sample(input logic signed [SAMPLE_W-1:0] audio);
      while ($urandom_range(99) < source_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_audio_in <= audio;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_sample(audio);
      @(negedge clock);
   endtask

   // Mixes full-scale extremes, quiet signals and fully random samples.
   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2, 3, 4: return SAMPLE_W'($signed($urandom_range(511)) - 256);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task send_random(input int count);
      for (int i = 0; i < count; i++) send_sample(random_sample());
   endtask

   // Stops offering samples and waits until every pending result is back.
   task wait_drained();
      req_valid <= 1'b0;
      while (board.weighted_expected.size() != 0) @(negedge clock);
      repeat (IDLE_GAP) @(negedge clock);
   endtask

   // Writes coef_plan into all registers, then pokes the unused index,
   // which must leave every coefficient as it is.
   task load_coefs();
      logic [COEF_W-1:0] junk;
      junk = $urandom;
      for (int i = 0; i < kwf_pkg::NUM_REGS; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= kwf_pkg::REG_IDX_BITS'(i);
         csr_wdata    <= coef_plan[i];
         board.set_coef(kwf_pkg::REG_IDX_BITS'(i), coef_plan[i]);
         @(negedge clock);
      end
      csr_index <= REG_UNUSED;
      csr_wdata <= junk;
      board.set_coef(REG_UNUSED, junk);
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off on request, counted
   // here so the sender keeps pushing samples into a full block.
   initial begin
      int held;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(negedge clock);
               held++;
            end
         end else begin
            rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   // Every result transfer is checked at the edge that completes it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_weighted_out);
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_audio_in = '0;
      csr_write_en = 1'b0;
      csr_index    = kwf_pkg::REG_SHELF_B0;
      csr_wdata    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed samples on the 48 kHz reset coefficients: silence, the
      // full-scale extremes, the smallest steps, sustained full scale and
      // a full-scale square wave at half the sample rate.
      send_sample('0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(24'sd1);
      send_sample(-24'sd1);
      repeat (3) send_sample(SAMPLE_MAX);
      repeat (3) send_sample(SAMPLE_MIN);
      repeat (4) begin
         send_sample(SAMPLE_MAX);
         send_sample(SAMPLE_MIN);
      end
      send_sample('0);
      send_sample('0);
      send_sample(24'sh123456);

      send_random(200);
      // The sender waits for every result once in the middle of a phase.
      wait_drained();
      send_random(100);

      // All taps at the largest value: the sections blow up and saturate.
      wait_drained();
      for (int i = 0; i < kwf_pkg::NUM_REGS; i++) coef_plan[i] = 32'h7FFF_FFFF;
      load_coefs();
      send_random(80);

      // All taps at the most negative value.
      wait_drained();
      for (int i = 0; i < kwf_pkg::NUM_REGS; i++) coef_plan[i] = 32'h8000_0000;
      load_coefs();
      send_random(80);

      // Random coefficients, with both channels running flat out.
      wait_drained();
      for (int i = 0; i < kwf_pkg::NUM_REGS; i++) coef_plan[i] = $urandom;
      load_coefs();
      source_idle_pct = 0;
      sink_stall_pct  = 0;
      send_random(150);
      source_idle_pct = IDLE_PCT;
      sink_stall_pct  = IDLE_PCT;

      // Shelf b0 at one and every other tap at zero.
      wait_drained();
      for (int i = 0; i < kwf_pkg::NUM_REGS; i++) coef_plan[i] = '0;
      coef_plan[kwf_pkg::REG_SHELF_B0] = COEF_ONE;
      load_coefs();
      send_random(60);

      // Back to the 48 kHz set, starting with a long receiver hold-off.
      wait_drained();
      for (int i = 0; i < kwf_pkg::NUM_REGS; i++) coef_plan[i] = kwf_pkg::COEF_RESET_Q29[i];
      load_coefs();
      hold_request = 1'b1;
      send_random(300);

      req_valid <= 1'b0;
      while (board.weighted_expected.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.weighted_expected.size() != 0)
         board.report($sformatf("%0d samples left without a result",
                                board.weighted_expected.size()));
      if (board.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
